@@ hw/rtl/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo valve PWM controller package
// Shared types, constants and the step angle table.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int unsigned PwmFreqHz  = 50;
  localparam int unsigned DutyBits   = 16;
  localparam int unsigned ClockBits  = 32;

  localparam int unsigned ActionW = 3;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned PulseW  = 15;
  localparam int unsigned PotW    = 7;
  localparam int unsigned IntvW   = 16;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [ActionW-1:0] ActTick  = 3'd0;
  localparam logic [ActionW-1:0] ActStep  = 3'd1;
  localparam logic [ActionW-1:0] ActSet   = 3'd2;
  localparam logic [ActionW-1:0] ActClose = 3'd3;
  localparam logic [ActionW-1:0] ActRead  = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgPulseMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPotClose = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPotOpen  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStepIntv = 3'd4;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindStep  = 2'd1,
    KindSet   = 2'd2,
    KindClose = 2'd3
  } kind_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    JobNone  = 2'd0,
    JobAngle = 2'd1,
    JobRead  = 2'd2
  } job_e;

  typedef struct packed {
    job_e            job;
    logic [7:0]      angle;
    logic [AdcW-1:0] adc;
  } job_t;

  function automatic logic [7:0] angle_lut(input logic [2:0] idx);
    logic [7:0] a;
    unique case (idx)
      3'd0:    a = 8'd180;
      3'd1:    a = 8'd155;
      3'd2:    a = 8'd130;
      3'd3:    a = 8'd90;
      3'd4:    a = 8'd50;
      default: a = 8'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/svpwm_front.sv @@
// ----------------------------------------------------------------------------
// Servo valve PWM front end
// Accepts items, keeps the clock and step sequence, and issues jobs.
// ----------------------------------------------------------------------------
module svpwm_front import svpwm_pkg::*; #(
  parameter int unsigned CLOCK_BITS = ClockBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [LevelW-1:0]  open_level_i,
  input  logic [AdcW-1:0]    adc_sample_i,
  input  logic [IntvW-1:0]   step_interval_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output job_t               job_o
);

  logic [CLOCK_BITS-1:0] clock_q, clock_d, last_q, last_d, elapsed;
  kind_e                 kind_q, kind_d;
  logic [2:0]            idx_q, idx_d;
  logic                  jv_q;
  job_t                  job_q, job_d;
  logic                  acc;

  assign in_ready_o  = !jv_q || job_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;
  assign elapsed     = clock_q - last_q;

  always_comb begin
    clock_d = clock_q;
    last_d  = last_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    job_d.job   = JobNone;
    job_d.angle = 8'd0;
    job_d.adc   = adc_sample_i;
    unique case (action_i)
      ActTick: clock_d = clock_q + 1'b1;
      ActStep: begin
        kind_d = KindStep;
        if (kind_q != KindStep) begin
          idx_d       = 3'd1;
          last_d      = clock_q;
          job_d.job   = JobAngle;
          job_d.angle = angle_lut(3'd1);
        end else if (elapsed >= CLOCK_BITS'(step_interval_i)) begin
          idx_d       = (idx_q < 3'd5) ? idx_q + 3'd1 : 3'd5;
          last_d      = clock_q;
          job_d.job   = JobAngle;
          job_d.angle = angle_lut(idx_d);
        end
      end
      ActSet: begin
        kind_d = KindSet;
        if (open_level_i == 2'd2) begin
          job_d.job = JobAngle;
          job_d.angle = 8'd0;
        end else if (open_level_i == 2'd1) begin
          job_d.job = JobAngle;
          job_d.angle = 8'd90;
        end
      end
      ActClose: begin
        kind_d = KindClose;
        job_d.job = JobAngle;
        job_d.angle = 8'd180;
      end
      ActRead: job_d.job = JobRead;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      last_q  <= '0;
      kind_q  <= KindNone;
      idx_q   <= 3'd0;
      jv_q    <= 1'b0;
    end else begin
      if (acc) begin
        clock_q <= clock_d;
        last_q  <= last_d;
        kind_q  <= kind_d;
        idx_q   <= idx_d;
        jv_q    <= 1'b1;
      end else if (job_ready_i) begin
        jv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      job_q <= job_d;
    end
  end

endmodule

@@ hw/rtl/svpwm_queue.sv @@
// ----------------------------------------------------------------------------
// Servo valve PWM job queue
// Two-entry queue that lets the front and back stall on their own.
// ----------------------------------------------------------------------------
module svpwm_queue import svpwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ hw/rtl/svpwm_back.sv @@
// ----------------------------------------------------------------------------
// Servo valve PWM back end
// Maps angles to duty by reciprocal multiplication and samples to position
// with a serial divider.
// ----------------------------------------------------------------------------
module svpwm_back import svpwm_pkg::*; #(
  parameter int unsigned PWM_FREQ_HZ = PwmFreqHz,
  parameter int unsigned DUTY_BITS   = DutyBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  input  logic [PulseW-1:0] pulse_min_i,
  input  logic [PulseW-1:0] pulse_max_i,
  input  logic [PotW-1:0]   pot_close_i,
  input  logic [PotW-1:0]   pot_open_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DutyW-1:0]  duty_o,
  output logic              duty_written_o,
  output logic [PosW-1:0]   valve_position_o,
  output logic [PosW-1:0]   position_change_o
);

  localparam logic [63:0] DutyMax = (64'd1 << DUTY_BITS) - 64'd1;
  localparam logic [63:0] DutyK   = 64'(PWM_FREQ_HZ) * DutyMax;
  // The duty divide by one million is split into a whole factor and a
  // fraction. The fraction uses a 35-bit reciprocal, exact for any 15-bit pulse.
  localparam logic [63:0] DutyQ   = DutyK / 64'd1000000;
  localparam logic [63:0] DutyR   = DutyK % 64'd1000000;
  localparam logic [63:0] DutyM   = ((DutyR << 35) + 64'd999999) / 64'd1000000;
  // Reciprocal of 180 scaled by 2^31, exact for magnitudes below 2^23.
  localparam logic [23:0] Recip180 = 24'd11930465;
  localparam int unsigned NW = 48;
  localparam int unsigned DW = 40;

  typedef enum logic [2:0] {
    StIdle, StMul, StPulse, StClamp, StDuty, StDiv, StDone, StOut
  } state_e;

  state_e              st_q;
  logic [NW-1:0]       num_q;
  logic [DW-1:0]       den_q;
  logic [NW-1:0]       quo_q;
  logic [DW:0]         rem_q;
  logic [5:0]          cnt_q;
  logic                neg_q, wr_q;
  logic signed [25:0]  prod_q;
  logic [PulseW-1:0]   pq_q, pulse_q;
  logic [DUTY_BITS-1:0] duty_q;
  logic [PosW-1:0]     pnow_q, pbef_q;
  logic [7:0]          ang_q;
  logic [DW:0]         rem_sh;
  logic signed [16:0]  span;
  logic signed [17:0]  lo_s, hi_s, psum;
  logic signed [19:0]  rnum;
  logic signed [14:0]  rden;
  logic [22:0]         pmag;
  logic [46:0]         qprod;
  logic [49:0]         fprod;
  logic [31:0]         dsum;

  assign span  = $signed({2'b0, pulse_max_i}) - $signed({2'b0, pulse_min_i});
  assign lo_s  = $signed({3'b0, pulse_min_i});
  assign hi_s  = $signed({3'b0, pulse_max_i});
  assign rnum  = $signed({8'b0, job_i.adc}) * 20'sd102
               - $signed({13'b0, pot_close_i}) * 20'sd4095;
  assign rden  = $signed({8'b0, pot_open_i}) - $signed({8'b0, pot_close_i});
  assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};

  // Truncating divide by 180 is done on the magnitude of the product.
  assign pmag  = 23'((prod_q < 0) ? -prod_q : prod_q);
  assign qprod = {24'b0, pmag} * {23'b0, Recip180};
  assign psum  = (neg_q ? -$signed({3'b0, pq_q}) : $signed({3'b0, pq_q})) + lo_s;
  assign fprod = {35'b0, pulse_q} * {15'b0, DutyM[34:0]};
  assign dsum  = 32'(pulse_q) * 32'(DutyQ[15:0]) + 32'(fprod[49:35]);

  assign job_ready_o       = st_q == StIdle;
  assign out_valid_o       = st_q == StOut;
  assign duty_o            = DutyW'(duty_q);
  assign duty_written_o    = wr_q;
  assign valve_position_o  = pnow_q;
  assign position_change_o = (pnow_q > pbef_q) ? pnow_q - pbef_q : pbef_q - pnow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      duty_q  <= '0;
      pnow_q  <= '0;
      pbef_q  <= '0;
      wr_q    <= 1'b0;
      num_q   <= '0;
      den_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      prod_q  <= '0;
      pq_q    <= '0;
      pulse_q <= '0;
      ang_q   <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          wr_q <= 1'b0;
          unique case (job_i.job)
            JobAngle: begin
              ang_q <= (job_i.angle > 8'd180) ? 8'd180 : job_i.angle;
              st_q  <= StMul;
            end
            JobRead: begin
              pbef_q <= pnow_q;
              if (rden == 15'sd0) begin
                pnow_q <= '0;
                st_q   <= StOut;
              end else begin
                // q = round(100*rnum / (4095*rden)), numerator doubled plus den.
                neg_q <= (rnum < 0) != (rden < 0);
                num_q <= NW'(200 * ((rnum < 0) ? -rnum : rnum))
                       + NW'(4095 * ((rden < 0) ? -rden : rden));
                den_q <= DW'(8190 * ((rden < 0) ? -rden : rden));
                quo_q <= '0;
                rem_q <= '0;
                cnt_q <= 6'(NW);
                st_q  <= StDiv;
              end
            end
            default: st_q <= StOut;
          endcase
        end
        StMul: begin
          prod_q <= $signed({18'b0, ang_q}) * span;
          st_q   <= StPulse;
        end
        StPulse: begin
          neg_q <= prod_q < 0;
          pq_q  <= qprod[45:31];
          st_q  <= StClamp;
        end
        StClamp: begin
          if (psum < lo_s) pulse_q <= pulse_min_i;
          else if (psum > hi_s) pulse_q <= pulse_max_i;
          else pulse_q <= psum[PulseW-1:0];
          st_q <= StDuty;
        end
        StDuty: begin
          duty_q <= (64'(dsum) > DutyMax) ? DUTY_BITS'(DutyMax) : DUTY_BITS'(dsum);
          wr_q   <= 1'b1;
          st_q   <= StOut;
        end
        StDiv: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[NW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NW-2:0], 1'b0};
          end
          num_q <= {num_q[NW-2:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_q <= StDone;
        end
        StDone: begin
          if (neg_q || quo_q == '0) pnow_q <= '0;
          else if (quo_q > NW'(100)) pnow_q <= 7'd100;
          else pnow_q <= PosW'(quo_q);
          st_q <= StOut;
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

@@ hw/rtl/servo_valve_stepped_pwm_controller_top.sv @@
// ----------------------------------------------------------------------------
// Servo valve stepped PWM controller
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (valid/ready) and each gives exactly one
// result beat on the output channel. The front end takes one item per cycle
// while the queue has room; it updates the millisecond clock and the step
// sequence. The back end works one job at a time: an angle job passes through
// multiply, reciprocal divide by 180, clamp and duty, a position read through
// a 48-step serial divider unless the pot span is zero, and other actions go
// straight to the output. Throughput is set by the back end occupancy.
// Configuration writes take effect on the next edge and must be made only
// while the block is idle; the block itself does not enforce this. Reset
// clears the clock, the step state, the held duty and the positions, and
// loads the register defaults. When the receiver stalls the result holds;
// the queue then fills and the input stops accepting.
// ----------------------------------------------------------------------------
module servo_valve_stepped_pwm_controller_top import svpwm_pkg::*; #(
  parameter int unsigned PWM_FREQ_HZ = PwmFreqHz,
  parameter int unsigned DUTY_BITS   = DutyBits,
  parameter int unsigned CLOCK_BITS  = ClockBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [LevelW-1:0]  open_level_i,
  input  logic [AdcW-1:0]    adc_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DutyW-1:0]   duty_o,
  output logic               duty_written_o,
  output logic [PosW-1:0]    valve_position_o,
  output logic [PosW-1:0]    position_change_o
);

  logic [PulseW-1:0] pmin_q, pmax_q;
  logic [PotW-1:0]   pclose_q, popen_q;
  logic [IntvW-1:0]  intv_q;
  logic              fv, fr, bv, br;
  job_t              fjob, bjob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q   <= 15'd400;
      pmax_q   <= 15'd2500;
      pclose_q <= 7'd0;
      popen_q  <= 7'd102;
      intv_q   <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPulseMin: pmin_q   <= cfg_data_i[PulseW-1:0];
        CfgPulseMax: pmax_q   <= cfg_data_i[PulseW-1:0];
        CfgPotClose: pclose_q <= cfg_data_i[PotW-1:0];
        CfgPotOpen:  popen_q  <= cfg_data_i[PotW-1:0];
        CfgStepIntv: intv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svpwm_front #(.CLOCK_BITS(CLOCK_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .open_level_i,
    .adc_sample_i, .step_interval_i(intv_q),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fjob)
  );

  svpwm_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fjob),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bjob)
  );

  svpwm_back #(.PWM_FREQ_HZ(PWM_FREQ_HZ), .DUTY_BITS(DUTY_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bv), .job_ready_o(br), .job_i(bjob),
    .pulse_min_i(pmin_q), .pulse_max_i(pmax_q), .pot_close_i(pclose_q),
    .pot_open_i(popen_q), .out_valid_o, .out_ready_i, .duty_o, .duty_written_o,
    .valve_position_o, .position_change_o
  );

endmodule

@@ tb/sv/svpwm_checker.sv @@
// ----------------------------------------------------------------------------
// Servo valve controller result checker
// Watches both channels, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module svpwm_checker import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ActionW-1:0] action_i,
  input  logic [LevelW-1:0]  open_level_i,
  input  logic [AdcW-1:0]    adc_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [DutyW-1:0]   duty_i,
  input  logic               duty_written_i,
  input  logic [PosW-1:0]    valve_position_i,
  input  logic [PosW-1:0]    position_change_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             written;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  change;
  } servo_result_t;

  servo_result_t expected_results[$];

  logic [PulseW-1:0]    pulse_lo, pulse_hi;
  logic [PotW-1:0]      pot_closed, pot_opened;
  logic [IntvW-1:0]     step_gap;
  logic [ClockBits-1:0] ms_count, step_stamp;
  kind_e                prev_kind;
  logic [2:0]           step_pos;
  logic [PosW-1:0]      pos_now, pos_prev;
  logic [DutyW-1:0]     duty_now;

  function automatic logic [DutyW-1:0] angle_to_duty(input int unsigned angle);
    longint lo, hi, a, pulse, d;
    lo = pulse_lo;
    hi = pulse_hi;
    a = (angle > 180) ? 180 : angle;
    pulse = (a * (hi - lo)) / 180 + lo;
    if (pulse < lo) pulse = lo;
    else if (pulse > hi) pulse = hi;
    d = pulse * PwmFreqHz * ((64'd1 << DutyBits) - 1) / 1000000;
    if (d > (64'd1 << DutyBits) - 1) d = (64'd1 << DutyBits) - 1;
    return d[DutyW-1:0];
  endfunction

  function automatic logic [PosW-1:0] adc_to_percent(input logic [AdcW-1:0] adc);
    longint num, den, un, ud, q;
    bit neg;
    if (pot_opened == pot_closed) return '0;
    num = 100 * (102 * longint'(adc) - 4095 * longint'(pot_closed));
    den = 4095 * (longint'(pot_opened) - longint'(pot_closed));
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    if (neg) q = -q;
    if (q < 0) q = 0;
    if (q > 100) q = 100;
    return q[PosW-1:0];
  endfunction

  task automatic predict_item(input logic [ActionW-1:0] act, input logic [LevelW-1:0] lvl,
                              input logic [AdcW-1:0] adc);
    servo_result_t r;
    logic wrote;
    wrote = 1'b0;
    case (act)
      ActTick: ms_count = ms_count + 1;
      ActStep: begin
        if (prev_kind == KindStep) begin
          if (ClockBits'(ms_count - step_stamp) >= step_gap) begin
            if (step_pos < 3'd5) step_pos = step_pos + 3'd1;
            duty_now = angle_to_duty(angle_lut(step_pos));
            step_stamp = ms_count;
            wrote = 1'b1;
          end
        end else begin
          step_pos = 3'd1;
          duty_now = angle_to_duty(angle_lut(3'd1));
          step_stamp = ms_count;
          wrote = 1'b1;
        end
        prev_kind = KindStep;
      end
      ActSet: begin
        if (lvl == 2'd2) begin
          duty_now = angle_to_duty(0);
          wrote = 1'b1;
        end else if (lvl == 2'd1) begin
          duty_now = angle_to_duty(90);
          wrote = 1'b1;
        end
        prev_kind = KindSet;
      end
      ActClose: begin
        duty_now = angle_to_duty(180);
        wrote = 1'b1;
        prev_kind = KindClose;
      end
      ActRead: begin
        pos_prev = pos_now;
        pos_now = adc_to_percent(adc);
      end
      default: ;
    endcase
    r.duty = duty_now;
    r.written = wrote;
    r.pos = pos_now;
    r.change = (pos_now > pos_prev) ? pos_now - pos_prev : pos_prev - pos_now;
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    servo_result_t want;
    if (!rst_ni) begin
      pulse_lo = 15'd400; pulse_hi = 15'd2500; pot_closed = 7'd0; pot_opened = 7'd102;
      step_gap = 16'd1000; ms_count = '0; step_stamp = '0; prev_kind = KindNone;
      step_pos = '0; pos_now = '0; pos_prev = '0; duty_now = '0;
      expected_results.delete();
      error_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPulseMin: pulse_lo = cfg_data_i[PulseW-1:0];
          CfgPulseMax: pulse_hi = cfg_data_i[PulseW-1:0];
          CfgPotClose: pot_closed = cfg_data_i[PotW-1:0];
          CfgPotOpen:  pot_opened = cfg_data_i[PotW-1:0];
          CfgStepIntv: step_gap = cfg_data_i[IntvW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (expected_results.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10) $display("ERROR: result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (want.duty !== duty_i || want.written !== duty_written_i ||
              want.pos !== valve_position_i || want.change !== position_change_i) begin
            error_count_o++;
            if (error_count_o <= 10)
              $display("ERROR: exp duty=%0d wr=%0d pos=%0d chg=%0d, got %0d %0d %0d %0d",
                       want.duty, want.written, want.pos, want.change,
                       duty_i, duty_written_i, valve_position_i, position_change_i);
          end
        end
      end
      // Predict after the compare so a same-edge beat is never matched early.
      if (in_valid_i && in_ready_i) predict_item(action_i, open_level_i, adc_sample_i);
      pending_o = expected_results.size();
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Servo valve stepped PWM controller testbench
// Directed and random actions over several register settings, with bursty
// input, a stalling receiver and a checker that predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  import svpwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ActionW-1:0] action_i = '0;
  logic [LevelW-1:0] open_level_i = '0;
  logic [AdcW-1:0] adc_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DutyW-1:0] duty_o;
  logic duty_written_o;
  logic [PosW-1:0] valve_position_o, position_change_o;
  int error_count, pending, results_seen;
  int items_sent;
  bit long_hold;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  servo_valve_stepped_pwm_controller_top uut (.*);

  svpwm_checker result_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .open_level_i, .adc_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .duty_i(duty_o),
    .duty_written_i(duty_written_o), .valve_position_i(valve_position_o),
    .position_change_i(position_change_o), .error_count_o(error_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 2000; hold++) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (($urandom_range(0, 299) < 100) && (($urandom & 3) == 0)) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDatW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_block;
    int n;
    while (pending != 0) @(negedge clk_i);
    for (n = 0; n < 150; n++) @(negedge clk_i);
  endtask

  // One beat; valid is left high afterwards so back-to-back beats never toggle it.
  task automatic send_action(input logic [ActionW-1:0] act, input logic [LevelW-1:0] lvl,
                             input logic [AdcW-1:0] adc);
    action_i <= act;
    open_level_i <= lvl;
    adc_sample_i <= adc;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int cycles);
    int n;
    in_valid_i <= 1'b0;
    for (n = 0; n < cycles; n++) @(negedge clk_i);
  endtask

  task automatic random_items(input int count, input int max_ticks);
    int n, burst;
    logic [ActionW-1:0] act;
    burst = $urandom_range(1, 12);
    for (n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: act = ActTick;
        6, 7, 8, 9, 10: act = ActStep;
        11, 12: act = ActSet;
        13: act = ActClose;
        14, 15, 16, 17: act = ActRead;
        default: act = ActionW'($urandom_range(5, 7));
      endcase
      // A run of ticks lets the step timer reach small intervals.
      if (act == ActTick && max_ticks > 1) repeat ($urandom_range(1, max_ticks))
        send_action(ActTick, LevelW'($urandom), AdcW'($urandom));
      else send_action(act, LevelW'($urandom), AdcW'($urandom));
      if (--burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        burst = $urandom_range(1, 12);
      end
    end
    idle_gap(0);
  endtask

  initial begin
    int lvl;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: default settings, first step, timing refusal, saturation.
    send_action(ActStep, '0, '0);
    send_action(ActStep, '0, '0);
    for (lvl = 0; lvl < 4; lvl++) send_action(ActSet, LevelW'(lvl), '0);
    send_action(ActClose, '0, '0);
    send_action(ActRead, '0, 12'hFFF);
    send_action(ActRead, '0, 12'h000);
    send_action(ActRead, '0, 12'd2048);
    send_action(3'd5, 2'd3, 12'hFFF);
    send_action(3'd7, '0, '0);
    idle_gap(0);
    drain_block();
    write_reg(CfgStepIntv, 0);
    write_reg(CfgPulseMin, 20000);
    write_reg(CfgPulseMax, 0);
    write_reg(CfgPotClose, 50);
    write_reg(CfgPotOpen, 50);
    for (lvl = 0; lvl < 7; lvl++) send_action(ActStep, '0, '0);
    send_action(ActRead, '0, 12'hABC);
    send_action(ActClose, '0, '0);
    send_action(ActTick, '0, '0);
    idle_gap(0);
    drain_block();

    // Random phases over several settings, extremes included.
    write_reg(CfgPulseMin, 400); write_reg(CfgPulseMax, 2500);
    write_reg(CfgPotClose, 0); write_reg(CfgPotOpen, 102); write_reg(CfgStepIntv, 3);
    random_items(220, 4);
    long_hold = 1'b1;
    random_items(40, 1);
    drain_block();
    write_reg(CfgPulseMin, 0); write_reg(CfgPulseMax, 20000);
    write_reg(CfgPotClose, 102); write_reg(CfgPotOpen, 0); write_reg(CfgStepIntv, 65535);
    random_items(150, 1);
    drain_block();
    write_reg(CfgPulseMin, 32767); write_reg(CfgPulseMax, 32767);
    write_reg(CfgPotClose, 127); write_reg(CfgPotOpen, 1); write_reg(CfgStepIntv, 1);
    random_items(150, 2);
    drain_block();
    repeat (3) begin
      write_reg(CfgPulseMin, $urandom_range(0, 32767));
      write_reg(CfgPulseMax, $urandom_range(0, 32767));
      write_reg(CfgPotClose, $urandom_range(0, 127));
      write_reg(CfgPotOpen, $urandom_range(0, 127));
      write_reg(CfgStepIntv, $urandom_range(0, 6));
      random_items(130, 5);
      drain_block();
    end

    $display("Sent %0d items over eight register settings; %0d results checked.",
             items_sent, results_seen);
    if (error_count == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
